### sv/longest_repeated_substring_assert.svh
// assertion helpers used by lrs_back
`ifndef LONGEST_REPEATED_SUBSTRING_ASSERT_SVH
`define LONGEST_REPEATED_SUBSTRING_ASSERT_SVH

// same-cycle implication, off during reset
`define LRS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define LRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lrs_pkg.sv
`default_nettype none
package lrs_pkg;
   localparam int MAX_LEN_DEF = 256;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] match_length;
      logic [7:0] match_position;
      logic       overflow;
   } rsp_type;

   // front to back: pending string
   typedef struct packed {
      logic valid;
      logic overflow;
   } job_ctl_type;

   // back to front
   typedef struct packed {
      logic busy;
      logic pop;
   } back_ctl_type;
endpackage
`default_nettype wire

### sv/longest_repeated_substring.sv
// load: n bytes load at one word per cycle while no string is pending or worked on; the
//   result follows the last word after the insertion sort of suffixes and the neighbour
//   prefix pass, run by the single-compare sequencer reading two text copies per cycle
// throughput: one string at a time; input stalls while its string is being worked on
// reset: synchronous, clears count, overflow flag, pending string and sequencer; no sweep
`default_nettype none
module longest_repeated_substring #(
   parameter int MAX_LEN = lrs_pkg::MAX_LEN_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire lrs_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      lrs_pkg::rsp_type rsp_data
);
   import lrs_pkg::*;
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);

   job_ctl_type   job;
   back_ctl_type  bctl;
   logic [CW-1:0] job_len;
   logic          wr_en;
   logic [AW-1:0] wr_addr, ta_addr, tb_addr;
   logic [7:0]    wr_data, ta_data, tb_data;

   // front: stores each word that fits, flags overflow, hands a finished string on
   lrs_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .bctl     (bctl),
      .job      (job),
      .job_len  (job_len),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   // two copies of the text so both suffixes are read in one cycle
   lrs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_a (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(ta_addr),
      .rd_data(ta_data)
   );

   lrs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_b (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(tb_addr),
      .rd_data(tb_data)
   );

   // back: suffix sort, neighbour prefix pass and result register
   lrs_back #(.MAX_LEN(MAX_LEN)) u_back (
      .clock    (clock),
      .reset    (reset),
      .job      (job),
      .job_len  (job_len),
      .bctl     (bctl),
      .ta_addr  (ta_addr),
      .tb_addr  (tb_addr),
      .ta_data  (ta_data),
      .tb_data  (tb_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );
endmodule
`default_nettype wire

### sv/lrs_ram.sv
`default_nettype none
module lrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

### sv/lrs_front.sv
`default_nettype none
module lrs_front #(
   parameter int MAX_LEN = lrs_pkg::MAX_LEN_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire lrs_pkg::req_type               req_data,
   input  wire lrs_pkg::back_ctl_type          bctl,
   output      lrs_pkg::job_ctl_type           job,
   output      logic [$clog2(MAX_LEN+1)-1:0]   job_len,
   output      logic                           wr_en,
   output      logic [$clog2(MAX_LEN)-1:0]     wr_addr,
   output      logic [7:0]                     wr_data
);
   import lrs_pkg::*;
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);

   logic [CW-1:0] count_ff, count_in, len_ff, len_in;
   logic          ovf_ff, ovf_in;
   job_ctl_type   job_ff, job_in;
   logic          take, room;

   assign req_ready = !job_ff.valid && !bctl.busy;
   assign take      = req_valid && req_ready;
   assign room      = count_ff < CW'(MAX_LEN);
   assign wr_en     = take && room;
   assign wr_addr   = count_ff[AW-1:0];
   assign wr_data   = req_data.char_byte;
   assign job       = job_ff;
   assign job_len   = len_ff;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      job_in   = job_ff;
      len_in   = len_ff;
      if (bctl.pop) begin
         job_in.valid = 1'b0;
      end
      if (take) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_data.is_last) begin
            job_in.valid    = 1'b1;
            job_in.overflow = ovf_in;
            len_in          = count_in;
            count_in        = '0;
            ovf_in          = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         job_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         job_ff   <= job_in;
      end
      len_ff <= len_in;
   end
endmodule
`default_nettype wire

### sv/lrs_back.sv
`default_nettype none
module lrs_back #(
   parameter int MAX_LEN = lrs_pkg::MAX_LEN_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lrs_pkg::job_ctl_type         job,
   input  wire logic [$clog2(MAX_LEN+1)-1:0] job_len,
   output      lrs_pkg::back_ctl_type        bctl,
   output      logic [$clog2(MAX_LEN)-1:0]   ta_addr,
   output      logic [$clog2(MAX_LEN)-1:0]   tb_addr,
   input  wire logic [7:0]                   ta_data,
   input  wire logic [7:0]                   tb_data,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      lrs_pkg::rsp_type             rsp_data
);
   import lrs_pkg::*;
   `include "longest_repeated_substring_assert.svh"
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);

   typedef enum logic [3:0] {
      S_IDLE, S_SORT_I, S_SORT_J, S_SORT_RD, S_CMP, S_CMP_W,
      S_LCP_I, S_LCP_A, S_LCP_B, S_LCP_C, S_LCP_W, S_DONE, S_OUT
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] n_ff, n_in, i_ff, i_in, j_ff, j_in, key_ff, key_in;
   logic [CW-1:0] val_ff, val_in, k_ff, k_in, best_ff, best_in, pos_ff, pos_in;
   logic          ovf_ff, ovf_in;
   rsp_type       rsp_ff, rsp_in;
   logic [CW-1:0] sa, sb;
   logic          ord_we;
   logic [AW-1:0] ord_wa, ord_ra;
   logic [CW-1:0] ord_wd, ord_rd;
   logic          resolve, less, finish;

   assign sa      = key_ff + k_ff;
   assign sb      = val_ff + k_ff;
   assign ta_addr = sa[AW-1:0];
   assign tb_addr = sb[AW-1:0];

   // suffix order array
   lrs_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_order (
      .clock  (clock),
      .wr_en  (ord_we),
      .wr_addr(ord_wa),
      .wr_data(ord_wd),
      .rd_addr(ord_ra),
      .rd_data(ord_rd)
   );

   assign bctl.busy = (state_ff != S_IDLE) && (state_ff != S_OUT);
   assign bctl.pop  = (state_ff == S_IDLE) && job.valid;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      k_in     = k_ff;
      best_in  = best_ff;
      pos_in   = pos_ff;
      ovf_in   = ovf_ff;
      rsp_in   = rsp_ff;
      ord_we   = 1'b0;
      ord_wa   = j_ff[AW-1:0];
      ord_wd   = key_ff;
      ord_ra   = AW'(j_ff - CW'(1));
      resolve  = 1'b0;
      less     = 1'b0;
      finish   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job.valid) begin
               n_in     = job_len;
               ovf_in   = job.overflow;
               i_in     = '0;
               best_in  = '0;
               pos_in   = '0;
               state_in = S_SORT_I;
            end
         end
         S_SORT_I: begin
            key_in = i_ff;
            j_in   = i_ff;
            if (i_ff == n_ff) begin
               i_in     = '0;
               state_in = S_LCP_I;
            end else begin
               state_in = S_SORT_J;
            end
         end
         S_SORT_J: begin
            if (j_ff == '0) begin
               ord_we   = 1'b1;
               i_in     = i_ff + CW'(1);
               state_in = S_SORT_I;
            end else begin
               state_in = S_SORT_RD;
            end
         end
         S_SORT_RD: begin
            val_in   = ord_rd;
            k_in     = '0;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (sa >= n_ff || sb >= n_ff) begin
               resolve = 1'b1;
               less    = (sa >= n_ff) && (sb < n_ff);
            end else begin
               state_in = S_CMP_W;
            end
         end
         S_CMP_W: begin
            if (ta_data != tb_data) begin
               resolve = 1'b1;
               less    = ta_data < tb_data;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = S_CMP;
            end
         end
         S_LCP_I: begin
            ord_ra = i_ff[AW-1:0];
            if (i_ff + CW'(1) >= n_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LCP_A;
            end
         end
         S_LCP_A: begin
            ord_ra   = AW'(i_ff + CW'(1));
            key_in   = ord_rd;
            state_in = S_LCP_B;
         end
         S_LCP_B: begin
            val_in   = ord_rd;
            k_in     = '0;
            state_in = S_LCP_C;
         end
         S_LCP_C: begin
            if (sa < n_ff && sb < n_ff) begin
               state_in = S_LCP_W;
            end else begin
               finish = 1'b1;
            end
         end
         S_LCP_W: begin
            if (ta_data == tb_data) begin
               k_in     = k_ff + CW'(1);
               state_in = S_LCP_C;
            end else begin
               finish = 1'b1;
            end
         end
         S_DONE: begin
            rsp_in.found          = best_ff != '0;
            rsp_in.match_length   = 8'(best_ff);
            rsp_in.match_position = (best_ff != '0) ? 8'(pos_ff) : 8'd0;
            rsp_in.overflow       = ovf_ff;
            state_in              = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // end of one suffix compare in the insertion sort
      if (resolve) begin
         ord_we = 1'b1;
         if (less) begin
            ord_wd   = val_ff;
            j_in     = j_ff - CW'(1);
            state_in = S_SORT_J;
         end else begin
            ord_wd   = key_ff;
            i_in     = i_ff + CW'(1);
            state_in = S_SORT_I;
         end
      end
      // end of one neighbour prefix measure
      if (finish) begin
         if (k_ff > best_ff) begin
            best_in = k_ff;
            pos_in  = (key_ff < val_ff) ? key_ff : val_ff;
         end
         i_in     = i_ff + CW'(1);
         state_in = S_LCP_I;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff    <= n_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      key_ff  <= key_in;
      val_ff  <= val_in;
      k_ff    <= k_in;
      best_ff <= best_in;
      pos_ff  <= pos_in;
      ovf_ff  <= ovf_in;
      rsp_ff  <= rsp_in;
   end

   `LRS_ASSERT_IMPL(a_pop_has_job, bctl.pop, job.valid, "pop without a pending string")
   `LRS_ASSERT_IMPL(a_no_self_cmp, state_ff == S_CMP_W, key_ff != val_ff,
                    "suffix compared with itself")
   `LRS_ASSERT_IMPL(a_match_fits, state_ff == S_DONE && best_ff != '0,
                    pos_ff < n_ff && best_ff < n_ff, "match runs past the string")
   `LRS_ASSERT_NEXT(a_out_holds, state_ff == S_OUT && !rsp_ready, state_ff == S_OUT,
                    "result dropped before it was taken")
endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
   import lrs_pkg::*;

   localparam int STORE_DEPTH  = MAX_LEN_DEF;
   // a whole string of one repeated byte is the slowest case for the compare loop,
   // so the limit covers the longest such string sent plus wide margin
   localparam int WATCHDOG_MAX = 24000000;
   localparam int HOLD_CYCLES  = 3000;
   localparam int RANDOM_WORDS = 1230;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   longest_repeated_substring dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock, period 8
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   req_type     word_queue[$];    // words still to be offered
   rsp_type     repeat_expect[$]; // predicted answers, oldest first
   logic [7:0]  text_copy[$];     // bytes of the string being loaded
   logic        text_dropped;     // a byte fell off the end of the store
   int          mismatch_count;
   int          answers_seen;
   int          idle_cycles;
   logic        req_taken;
   int          burst_left;
   int          gap_left;
   int          stall_left;
   logic        hold_done;
   logic        stimulus_done = 1'b0;

   // true if the suffix at a sorts before the suffix at b
   function automatic logic suffix_before(input logic [7:0] txt[$], input int a,
                                          input int b, input int n);
      int i;
      int j;
      i = a;
      j = b;
      while (i < n && j < n) begin
         if (txt[i] != txt[j]) return txt[i] < txt[j];
         i++;
         j++;
      end
      return (i >= n) && (j < n);
   endfunction

   // longest repeated substring of the loaded string via sorted suffixes
   function automatic rsp_type predict_repeat(input logic [7:0] txt[$], input logic dropped);
      int      n;
      int      ord[STORE_DEPTH];
      int      j;
      int      k;
      int      best_len;
      int      best_pos;
      int      a;
      int      b;
      rsp_type ans;
      n        = txt.size();
      best_len = 0;
      best_pos = 0;
      for (int i = 0; i < n; i++) begin
         j = i;
         while (j > 0 && suffix_before(txt, i, ord[j-1], n)) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = i;
      end
      for (int i = 0; i + 1 < n; i++) begin
         a = ord[i];
         b = ord[i+1];
         k = 0;
         while (a + k < n && b + k < n && txt[a+k] == txt[b+k]) k++;
         // strict compare keeps the first pair in sorted order on a tie
         if (k > best_len) begin
            best_len = k;
            best_pos = (a < b) ? a : b;
         end
      end
      ans.found          = (best_len > 0);
      ans.match_length   = best_len[7:0];
      ans.match_position = (best_len > 0) ? best_pos[7:0] : 8'd0;
      ans.overflow       = dropped;
      return ans;
   endfunction

   // queue one whole string, last flag on its final byte
   task automatic add_string(input logic [7:0] txt[$]);
      req_type w;
      foreach (txt[i]) begin
         w.char_byte = txt[i];
         w.is_last   = (i == txt.size() - 1);
         word_queue.push_back(w);
      end
   endtask

   // random string; a narrow alphabet makes repeats likely
   task automatic add_random_string(input int len, output int added);
      logic [7:0] txt[$];
      int         alpha;
      int         base;
      alpha = $urandom_range(0, 3) == 0 ? 256 : $urandom_range(1, 4);
      base  = $urandom_range(0, 256 - alpha);
      for (int i = 0; i < len; i++) txt.push_back(8'(base + $urandom_range(0, alpha - 1)));
      add_string(txt);
      added = len;
   endtask

   // stimulus
   initial begin
      logic [7:0] txt[$];
      int         total;
      int         added;
      int         len;
      // single byte, no repeat
      txt = '{8'h41};
      add_string(txt);
      // shortest repeat
      txt = '{8'h61, 8'h61};
      add_string(txt);
      // zero byte and top byte, compared unsigned
      txt = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h7f};
      add_string(txt);
      // no pair shares a first byte
      txt = '{8'h01, 8'h02, 8'h80, 8'hfe};
      add_string(txt);
      // overlapping repeat, tie broken by smallest substring
      txt = '{8'h62, 8'h61, 8'h6e, 8'h61, 8'h6e, 8'h61};
      add_string(txt);
      txt = '{8'h7a, 8'h7a, 8'h61, 8'h61};
      add_string(txt);
      // a suffix that is a prefix of another sorts first
      txt = {};
      repeat (30) txt.push_back(8'h55);
      add_string(txt);
      // exactly a full store
      txt = {};
      for (int i = 0; i < STORE_DEPTH; i++) txt.push_back(8'($urandom));
      add_string(txt);
      // store full: extra bytes dropped, the last one among them
      txt = {};
      for (int i = 0; i < STORE_DEPTH + 5; i++) txt.push_back(8'($urandom));
      add_string(txt);
      // random part: mostly short strings, a few long ones
      total = 0;
      while (total < RANDOM_WORDS) begin
         case ($urandom_range(0, 19))
            0:       len = $urandom_range(40, 120);
            1:       len = (total < 20) ? STORE_DEPTH + $urandom_range(1, 8) : 2;
            default: len = $urandom_range(1, 14);
         endcase
         add_random_string(len, added);
         total += added;
      end
      stimulus_done = 1'b1;
   end

   // reset and initial drive values
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      text_dropped   = 1'b0;
      mismatch_count = 0;
      answers_seen   = 0;
      idle_cycles    = 0;
      req_taken      = 1'b0;
      burst_left     = 0;
      gap_left       = 0;
      stall_left     = 0;
      hold_done      = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // sender: bursts of words with random gaps, changes on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (word_queue.size() > 0) begin
               req_data  <= word_queue.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 40);
                  // some bursts run with no gap after them
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: own stall pattern, plus one long hold-off to back up the block
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && answers_seen == 12) begin
            hold_done  <= 1'b1;
            stall_left <= HOLD_CYCLES;
            rsp_ready  <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if ($urandom_range(0, 9) < 3) begin
            stall_left <= $urandom_range(0, 5);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
         end
      end
   end

   // monitor: sample at the rising edge, predict when a string's last word is accepted
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            if (text_copy.size() < STORE_DEPTH) text_copy.push_back(req_data.char_byte);
            else text_dropped = 1'b1;
            if (req_data.is_last) begin
               repeat_expect.push_back(predict_repeat(text_copy, text_dropped));
               text_copy    = {};
               text_dropped = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            answers_seen++;
            if (repeat_expect.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected answer %p", rsp_data);
            end else begin
               rsp_type want;
               want = repeat_expect.pop_front();
               if (rsp_data.found !== want.found
                   || rsp_data.match_length !== want.match_length
                   || rsp_data.match_position !== want.match_position
                   || rsp_data.overflow !== want.overflow) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("answer %0d mismatch: expected %p got %p",
                              answers_seen, want, rsp_data);
               end
            end
         end
         // watchdog on cycles with no word moving either way
         if (req_taken || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // end of run: all sent, all answered, then a short drain
   initial begin
      wait (stimulus_done);
      while (word_queue.size() != 0 || req_valid || repeat_expect.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && repeat_expect.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire

### longest_repeated_substring.f
+incdir+sv
sv/lrs_pkg.sv
sv/lrs_ram.sv
sv/lrs_front.sv
sv/lrs_back.sv
sv/longest_repeated_substring.sv
tb/tb.sv
